FILE: rtl/qrspf_pkg.sv
// Shared types, codes and helpers for the QRS pre-processing filter chain.
// No dependencies; imported by the ring memory and the top level.
package qrspf_pkg;

    // Ring selectors for the shared read path.
    localparam logic [1:0] R_X  = 2'd0;
    localparam logic [1:0] R_LP = 2'd1;
    localparam logic [1:0] R_HP = 2'd2;
    localparam logic [1:0] R_Q  = 2'd3;

    // Operations of the shared accumulate unit.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_ADD2 = 3'd2;
    localparam logic [2:0] OP_SUB2 = 3'd3;
    localparam logic [2:0] OP_ADDD = 3'd4;
    localparam logic [2:0] OP_SUBD = 3'd5;
    localparam logic [2:0] OP_MIN  = 3'd6;
    localparam logic [2:0] OP_RNM  = 3'd7;

    localparam int OFF_W = 6;

    typedef struct packed {
        logic [1:0]       ring;
        logic             absolute;
        logic [OFF_W-1:0] off;
        logic [2:0]       op;
    } t_term;

    // Signed division by a power of two that truncates toward zero.
    function automatic logic [31:0] tdiv_pow2(input logic [31:0] v, input int sh);
        logic [31:0] mag;
        begin
            mag = 32'd0 - v;
            if (v[31]) begin
                tdiv_pow2 = 32'd0 - (mag >> sh);
            end else begin
                tdiv_pow2 = v >> sh;
            end
        end
    endfunction

endpackage

FILE: rtl/qrspf_ring.sv
// Ring memory for one filter stage: one write port, one registered read port.
// Per-entry valid bits make never-written entries read as zero. Uses qrspf_pkg.
module qrspf_ring
    import qrspf_pkg::*;
#(
    parameter int DEPTH = 40,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_valid[i_raddr]) begin
            r_rdata <= r_mem[i_raddr];
        end else begin
            r_rdata <= '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/qrs_preprocess_filter_chain.sv
// Integer QRS pre-processing chain: low-pass, high-pass, derivative, square and
// moving-window integration, run by a sequencer over one shared adder.
// Depends on qrspf_pkg and qrspf_ring.
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  input   | i_valid, o_stall, i_sample     | in
//  output  | o_valid, i_stall, o_*_out      | out
//
// Each request runs its read phases at one ring read per cycle into the shared adder.
// The window division is one reciprocal multiply on the shared multiplier. The next
// request can be accepted in the cycle after the result is loaded.
// A request that lands on RENORM_INDEX adds a minimum walk and a subtract pass over
// the low-pass ring.
// Reset clears the rings' valid bits, the write index and both handshakes.
// The result register lets the next request start while a result waits.
module qrs_preprocess_filter_chain
    import qrspf_pkg::*;
#(
    parameter int RING_DEPTH    = 40,
    parameter int WINDOW_LENGTH = 30,
    parameter int RENORM_INDEX  = 34
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_low_pass_out,
    output logic signed [31:0] o_high_pass_out,
    output logic signed [31:0] o_derivative_out,
    output logic signed [31:0] o_squared_out,
    output logic signed [31:0] o_integrated_out
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int KW = $clog2(RING_DEPTH + 1);

    // Rounded-up reciprocal of the window, exact for every 32-bit magnitude.
    localparam int          DIV_SH    = $clog2(WINDOW_LENGTH);
    localparam logic [32:0] DIV_MAGIC =
        33'((((65'd1 << (32 + DIV_SH)) + 65'(WINDOW_LENGTH)) - 65'd1) /
            65'(WINDOW_LENGTH));

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LPX   = 5'd1;
    localparam logic [4:0] S_LPDIV = 5'd2;
    localparam logic [4:0] S_LPY   = 5'd3;
    localparam logic [4:0] S_LPWR  = 5'd4;
    localparam logic [4:0] S_MIN   = 5'd5;
    localparam logic [4:0] S_SUB   = 5'd6;
    localparam logic [4:0] S_HP    = 5'd7;
    localparam logic [4:0] S_HPWR  = 5'd8;
    localparam logic [4:0] S_DV    = 5'd9;
    localparam logic [4:0] S_DDIV  = 5'd10;
    localparam logic [4:0] S_MUL   = 5'd11;
    localparam logic [4:0] S_ABS   = 5'd12;
    localparam logic [4:0] S_DIV   = 5'd13;
    localparam logic [4:0] S_QWR   = 5'd14;
    localparam logic [4:0] S_INT   = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;

    function automatic logic [IW-1:0] f_back(input logic [IW-1:0] n,
                                             input logic [OFF_W-1:0] k);
        logic [IW:0] kk;
        logic [IW:0] nn;
        begin
            kk = (IW+1)'(k);
            if (kk >= (IW+1)'(RING_DEPTH)) begin
                kk = kk - (IW+1)'(RING_DEPTH);
            end
            nn = (IW+1)'(n) + (IW+1)'(RING_DEPTH) - kk;
            if (nn >= (IW+1)'(RING_DEPTH)) begin
                nn = nn - (IW+1)'(RING_DEPTH);
            end
            f_back = nn[IW-1:0];
        end
    endfunction

    logic [4:0]    r_state;
    logic [IW-1:0] r_idx;
    logic [KW-1:0] r_k;
    logic          r_pend;
    logic [1:0]    r_pring;
    logic [2:0]    r_pop;
    logic [IW-1:0] r_paddr;
    logic [31:0]   r_acc;
    logic [31:0]   r_min;
    logic [31:0]   r_lp;
    logic [31:0]   r_hp;
    logic [31:0]   r_d;
    logic [31:0]   r_prod;
    logic [31:0]   r_sq;
    logic [31:0]   r_dq;
    logic          r_ovalid;
    logic [31:0]   r_o_lp, r_o_hp, r_o_d, r_o_sq, r_o_int;

    t_term         term;
    logic [KW-1:0] cnt;
    logic          is_rd;
    logic [IW-1:0] raddr;
    logic [31:0]   v;
    logic [31:0]   f_v;
    logic [31:0]   n_acc;
    logic [31:0]   diff;
    logic          rnm_we;
    logic [31:0]   mul_a;
    logic [32:0]   mul_b;
    logic [64:0]   mul_p;
    logic          accept;

    logic          x_we, lp_we, hp_we, q_we;
    logic [IW-1:0] lp_waddr;
    logic [31:0]   lp_wdata;
    logic [15:0]   x_rd;
    logic [31:0]   lp_rd, hp_rd, q_rd;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // Term table of every read phase.
    always_comb begin
        term = '{ring: R_X, absolute: 1'b0, off: '0, op: OP_ADD};
        cnt  = '0;
        case (r_state)
            S_LPX: begin
                cnt = KW'(2);
                if (r_k == '0) begin
                    term = '{ring: R_X, absolute: 1'b0, off: OFF_W'(6), op: OP_SUB2};
                end else begin
                    term = '{ring: R_X, absolute: 1'b0, off: OFF_W'(12), op: OP_ADD};
                end
            end
            S_LPY: begin
                cnt = KW'(2);
                if (r_k == '0) begin
                    term = '{ring: R_LP, absolute: 1'b0, off: OFF_W'(1), op: OP_ADD2};
                end else begin
                    term = '{ring: R_LP, absolute: 1'b0, off: OFF_W'(2), op: OP_SUB};
                end
            end
            S_MIN: begin
                cnt  = KW'(RING_DEPTH);
                term = '{ring: R_LP, absolute: 1'b1, off: '0, op: OP_MIN};
            end
            S_SUB: begin
                cnt  = KW'(RING_DEPTH);
                term = '{ring: R_LP, absolute: 1'b1, off: '0, op: OP_RNM};
            end
            S_HP: begin
                cnt = KW'(5);
                case (r_k)
                    KW'(0): term = '{ring: R_HP, absolute: 1'b0, off: OFF_W'(1), op: OP_ADD};
                    KW'(1): term = '{ring: R_LP, absolute: 1'b0, off: '0, op: OP_SUBD};
                    KW'(2): term = '{ring: R_LP, absolute: 1'b0, off: OFF_W'(16), op: OP_ADD};
                    KW'(3): term = '{ring: R_LP, absolute: 1'b0, off: OFF_W'(17), op: OP_SUB};
                    default: term = '{ring: R_LP, absolute: 1'b0, off: OFF_W'(32),
                                      op: OP_ADDD};
                endcase
            end
            S_DV: begin
                cnt = KW'(3);
                case (r_k)
                    KW'(0): term = '{ring: R_HP, absolute: 1'b0, off: OFF_W'(1), op: OP_ADD};
                    KW'(1): term = '{ring: R_HP, absolute: 1'b0, off: OFF_W'(3), op: OP_SUB};
                    default: term = '{ring: R_HP, absolute: 1'b0, off: OFF_W'(4),
                                      op: OP_SUB2};
                endcase
            end
            S_INT: begin
                cnt  = KW'(WINDOW_LENGTH);
                term = '{ring: R_Q, absolute: 1'b0, off: r_k[OFF_W-1:0], op: OP_ADD};
            end
            default: begin
                cnt = '0;
            end
        endcase
    end

    assign is_rd = (r_state == S_LPX) || (r_state == S_LPY) || (r_state == S_MIN) ||
                   (r_state == S_SUB) || (r_state == S_HP) || (r_state == S_DV) ||
                   (r_state == S_INT);
    assign raddr = term.absolute ? r_k[IW-1:0] : f_back(r_idx, term.off);

    // Returned data of the read issued last cycle.
    always_comb begin
        case (r_pring)
            R_X:     v = {{16{x_rd[15]}}, x_rd};
            R_LP:    v = lp_rd;
            R_HP:    v = hp_rd;
            default: v = q_rd;
        endcase
    end

    // The shared accumulate unit: one adder with a small operand selector.
    always_comb begin
        case (r_pop)
            OP_ADD:  f_v = v;
            OP_SUB:  f_v = 32'd0 - v;
            OP_ADD2: f_v = v << 1;
            OP_SUB2: f_v = 32'd0 - (v << 1);
            OP_ADDD: f_v = tdiv_pow2(v, 5);
            OP_SUBD: f_v = 32'd0 - tdiv_pow2(v, 5);
            default: f_v = 32'd0;
        endcase
        if (!r_pend) begin
            n_acc = r_acc;
        end else if (r_pop == OP_MIN) begin
            n_acc = ((r_paddr == '0) || ($signed(v) < $signed(r_acc))) ? v : r_acc;
        end else begin
            n_acc = r_acc + f_v;
        end
    end

    assign diff   = v - r_min;
    assign rnm_we = (r_state == S_SUB) && r_pend && !diff[31];

    // One multiplier serves the square and then the division by the window.
    assign mul_a = (r_state == S_MUL) ? r_acc : r_dq;
    assign mul_b = (r_state == S_MUL) ? {1'b0, r_acc} : DIV_MAGIC;
    assign mul_p = 65'(mul_a) * 65'(mul_b);

    assign x_we     = accept;
    assign lp_we    = (r_state == S_LPWR) || rnm_we;
    assign lp_waddr = (r_state == S_LPWR) ? r_idx : r_paddr;
    assign lp_wdata = (r_state == S_LPWR) ? r_acc : diff;
    assign hp_we    = (r_state == S_HPWR);
    assign q_we     = (r_state == S_QWR);

    qrspf_ring #(.DEPTH(RING_DEPTH), .WIDTH(16)) u_x_ring (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(x_we), .i_waddr(r_idx),
        .i_wdata(i_sample), .i_raddr(raddr), .o_rdata(x_rd)
    );

    qrspf_ring #(.DEPTH(RING_DEPTH), .WIDTH(32)) u_lp_ring (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(lp_we), .i_waddr(lp_waddr),
        .i_wdata(lp_wdata), .i_raddr(raddr), .o_rdata(lp_rd)
    );

    qrspf_ring #(.DEPTH(RING_DEPTH), .WIDTH(32)) u_hp_ring (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(hp_we), .i_waddr(r_idx),
        .i_wdata(r_acc), .i_raddr(raddr), .o_rdata(hp_rd)
    );

    // The integration ring keeps each squared value already divided by the window.
    qrspf_ring #(.DEPTH(RING_DEPTH), .WIDTH(32)) u_q_ring (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(q_we), .i_waddr(r_idx),
        .i_wdata(r_sq[31] ? (32'd0 - r_dq) : r_dq), .i_raddr(raddr), .o_rdata(q_rd)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_k      <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            if (is_rd) begin
                if (r_k != cnt) begin
                    r_k    <= r_k + KW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_k    <= '0;
                    r_pend <= 1'b0;
                    case (r_state)
                        S_LPX:   r_state <= S_LPDIV;
                        S_LPY:   r_state <= S_LPWR;
                        S_MIN:   r_state <= S_SUB;
                        S_SUB:   r_state <= S_HP;
                        S_HP:    r_state <= S_HPWR;
                        S_DV:    r_state <= S_DDIV;
                        default: r_state <= S_DONE;
                    endcase
                end
            end else begin
                case (r_state)
                    S_IDLE:  if (accept) r_state <= S_LPX;
                    S_LPDIV: r_state <= S_LPY;
                    S_LPWR: begin
                        if ((RENORM_INDEX < RING_DEPTH) &&
                            (r_idx == IW'(RENORM_INDEX))) begin
                            r_state <= S_MIN;
                        end else begin
                            r_state <= S_HP;
                        end
                    end
                    S_HPWR:  r_state <= S_DV;
                    S_DDIV:  r_state <= S_MUL;
                    S_MUL:   r_state <= S_ABS;
                    S_ABS:   r_state <= S_DIV;
                    S_DIV:   r_state <= S_QWR;
                    S_QWR:   r_state <= S_INT;
                    S_DONE: begin
                        if (!r_ovalid || !i_stall) begin
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                            r_idx    <= (r_idx == IW'(RING_DEPTH - 1)) ? '0
                                                                      : r_idx + IW'(1);
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (is_rd) begin
            r_pring <= term.ring;
            r_pop   <= term.op;
            r_paddr <= raddr;
        end
        case (r_state)
            S_IDLE:  r_acc <= {{16{i_sample[15]}}, i_sample};
            S_LPDIV: r_acc <= tdiv_pow2(r_acc, 5);
            S_LPWR: begin
                r_lp  <= r_acc;
                r_acc <= 32'd0;
            end
            S_SUB: begin
                if (rnm_we && (r_paddr == r_idx)) begin
                    r_lp <= diff;
                end
                r_acc <= 32'd0;
            end
            S_MIN: begin
                r_acc <= n_acc;
                r_min <= n_acc;
            end
            S_HPWR: begin
                r_hp  <= r_acc;
                r_acc <= r_acc << 1;
            end
            S_DDIV:  r_acc <= tdiv_pow2(r_acc, 3);
            S_MUL: begin
                r_d    <= r_acc;
                r_prod <= mul_p[31:0];
            end
            S_ABS: begin
                // The magnitude equals the absolute value as unsigned, even for the
                // most negative value.
                r_sq <= r_prod[31] ? (32'd0 - r_prod) : r_prod;
                r_dq <= r_prod[31] ? (32'd0 - r_prod) : r_prod;
            end
            S_DIV:   r_dq  <= 32'(mul_p >> (32 + DIV_SH));
            S_QWR:   r_acc <= 32'd0;
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    r_o_lp  <= r_lp;
                    r_o_hp  <= r_hp;
                    r_o_d   <= r_d;
                    r_o_sq  <= r_sq;
                    r_o_int <= r_acc;
                end
            end
            default: r_acc <= n_acc;
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_low_pass_out   = r_o_lp;
    assign o_high_pass_out  = r_o_hp;
    assign o_derivative_out = r_o_d;
    assign o_squared_out    = r_o_sq;
    assign o_integrated_out = r_o_int;

    a_idx_moves_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != $past(r_idx)) |-> $past(r_state == S_DONE))
        else $error("write index moved outside result load");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IW'(RING_DEPTH - 1))
        else $error("write index beyond ring depth");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside result load");

    a_counter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_rd |-> (r_k <= cnt))
        else $error("read counter beyond term count");

endmodule

FILE: tb/tb.sv
// Self-checking bench for the QRS pre-processing filter chain.
// Depends on the rtl top level qrs_preprocess_filter_chain; no package types are needed.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH  = 40;
    localparam int WIN    = 30;
    localparam int RENORM = 34;
    localparam int N_RAND = 1830;

    typedef struct packed {
        logic [31:0] lp;
        logic [31:0] hp;
        logic [31:0] d;
        logic [31:0] sq;
        logic [31:0] integ;
    } t_chain_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [15:0] i_sample = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_low_pass_out, o_high_pass_out, o_derivative_out;
    logic signed [31:0] o_squared_out, o_integrated_out;

    qrs_preprocess_filter_chain i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sample(i_sample), .o_valid(o_valid), .i_stall(i_stall),
        .o_low_pass_out(o_low_pass_out), .o_high_pass_out(o_high_pass_out),
        .o_derivative_out(o_derivative_out), .o_squared_out(o_squared_out),
        .o_integrated_out(o_integrated_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Filter state mirrored from the specification.
    logic [31:0] x_ring [DEPTH];
    logic [31:0] lp_ring [DEPTH];
    logic [31:0] hp_ring [DEPTH];
    logic [31:0] d_ring [DEPTH];
    logic [31:0] sq_ring [DEPTH];
    int          widx;

    t_chain_out  expected_q [$];
    int          mismatches = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;

    function automatic logic [31:0] trunc_div(logic [31:0] v, int unsigned dv);
        logic [31:0] mag;
        mag = 32'd0 - v;
        if (v[31]) return 32'd0 - (mag / dv);
        return v / dv;
    endfunction

    function automatic int back(int n, int k);
        return (n + 2 * DEPTH - k) % DEPTH;
    endfunction

    function automatic void clear_chain();
        for (int i = 0; i < DEPTH; i++) begin
            x_ring[i] = '0; lp_ring[i] = '0; hp_ring[i] = '0;
            d_ring[i] = '0; sq_ring[i] = '0;
        end
        widx = 0;
    endfunction

    function automatic t_chain_out filter_sample(logic [15:0] s);
        t_chain_out  r;
        logic [31:0] t, mn, acc, diff, sq;
        int          n;
        n = widx;
        x_ring[n] = {{16{s[15]}}, s};
        t = x_ring[n] - 2 * x_ring[back(n, 6)] + x_ring[back(n, 12)];
        lp_ring[n] = 2 * lp_ring[back(n, 1)] - lp_ring[back(n, 2)] + trunc_div(t, 32);
        if (n == RENORM) begin
            mn = lp_ring[0];
            for (int i = 1; i < DEPTH; i++)
                if ($signed(lp_ring[i]) < $signed(mn)) mn = lp_ring[i];
            // Entries whose difference wraps negative are left alone.
            for (int i = 0; i < DEPTH; i++) begin
                diff = lp_ring[i] - mn;
                if (!diff[31]) lp_ring[i] = diff;
            end
        end
        hp_ring[n] = hp_ring[back(n, 1)] - trunc_div(lp_ring[n], 32)
                     + lp_ring[back(n, 16)] - lp_ring[back(n, 17)]
                     + trunc_div(lp_ring[back(n, 32)], 32);
        t = 2 * hp_ring[n] + hp_ring[back(n, 1)] - hp_ring[back(n, 3)]
            - 2 * hp_ring[back(n, 4)];
        d_ring[n] = trunc_div(t, 8);
        sq = d_ring[n] * d_ring[n];
        if (sq[31]) sq = 32'd0 - sq;
        sq_ring[n] = sq;
        acc = '0;
        for (int i = 0; i < WIN; i++) acc += trunc_div(sq_ring[back(n, i)], WIN);
        r = '{lp_ring[n], hp_ring[n], d_ring[n], sq, acc};
        widx = (n + 1) % DEPTH;
        return r;
    endfunction

    // Directed samples: zero from reset, extremes, steps and alternation.
    localparam int N_DIR = 20;
    logic [15:0] dir_sample [N_DIR] = '{
        16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
        16'h5555, 16'hAAAA, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000};

    // Valid stays high after acceptance until the next idle cycle or hold-off.
    task automatic send_sample(logic [15:0] s);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        expected_q.push_back(filter_sample(s));
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(400)) - 200);
            2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(4000) * ($urandom_range(1) ? 1 : -1));
        endcase
    endfunction

    // Receiver: random stall, checks each accepted result against the oldest request.
    always @(posedge i_clk) begin
        t_chain_out e, a;
        if (i_rst_n && o_valid && !i_stall) begin
            a = '{o_low_pass_out, o_high_pass_out, o_derivative_out,
                  o_squared_out, o_integrated_out};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", a);
            end else begin
                e = expected_q.pop_front();
                if (e !== a) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp lp=%h hp=%h d=%h sq=%h int=%h got %h %h %h %h %h",
                                 e.lp, e.hp, e.d, e.sq, e.integ, a.lp, a.hp, a.d,
                                 a.sq, a.integ);
                end
            end
        end
        i_stall <= ($urandom_range(99) < snk_idle_pct);
    end

    initial begin
        clear_chain();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIR; i++) send_sample(dir_sample[i]);
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 59 : 0;
            snk_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 28 : 0;
            for (int i = 0; i < N_RAND / 3; i++) begin
                send_sample(rand_sample($urandom_range(3)));
                // Hold off until the pipeline drains, once per phase.
                if (i == 100) begin
                    i_valid <= 1'b0;
                    wait (expected_q.size() == 0);
                    @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
